### rtl/core/nd_pixel_address_generator_assert.svh
// ----------------------------------------------------------------------------
// nd_pixel_address_generator assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ND_PIXEL_ADDRESS_GENERATOR_ASSERT_SVH
`define ND_PIXEL_ADDRESS_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define NDPAG_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ndpag assertion failed");
`define NDPAG_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("ndpag assertion failed");
`else
`define NDPAG_ASSERT(lbl, prop)
`define NDPAG_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### rtl/core/ndpag_pkg.sv
// ----------------------------------------------------------------------------
// ndpag_pkg
// Widths, limits and shared types of the N-dimensional pixel address generator.
// ----------------------------------------------------------------------------
package ndpag_pkg;

	localparam int POS_W         = 48;
	localparam int STRIDE_W      = 49;
	localparam int COORD_W       = 13;
	localparam int SIZE_W        = 13;
	localparam int OCOORD_W      = 12;
	localparam int STEP_W        = 12;
	localparam int MASK_W        = 4;
	localparam int NUM_DIMS_W    = 3;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 49;
	localparam int CFG_DIM_REGS  = 4;
	localparam int MAX_DIMS_DEF  = 4;
	localparam int DIM_MAX       = 4096;
	localparam int SENTINEL_SIZE = 3;
	localparam int DIV_CNT_W     = $clog2(POS_W + 1);

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] count;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (32'(v) > DIM_MAX) begin
			r = SIZE_W'(DIM_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

### rtl/core/ndpag_div.sv
// ----------------------------------------------------------------------------
// ndpag_div
// Restoring divider, one quotient bit per cycle; the dividend is taken from
// the top of the word, so count sets how many bits are resolved.
// ----------------------------------------------------------------------------
module ndpag_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ndpag_pkg::div_ctl_t            ctl,
	input  logic [ndpag_pkg::POS_W-1:0]    dividend,
	input  logic [ndpag_pkg::STRIDE_W-1:0] divisor,
	output ndpag_pkg::div_sts_t            sts,
	output logic [ndpag_pkg::POS_W-1:0]    quotient,
	output logic [ndpag_pkg::STRIDE_W-1:0] remainder
);
	import ndpag_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [STRIDE_W-1:0]  divisor_q;
	logic [STRIDE_W-1:0]  rem_q;
	logic [POS_W-1:0]     quo_q;
	logic [STRIDE_W:0]    trial;
	logic [STRIDE_W+1:0]  diff;
	logic                 borrow;

	assign trial  = {rem_q, quo_q[POS_W-1]};
	assign diff   = {1'b0, trial} - {2'b00, divisor_q};
	assign borrow = diff[STRIDE_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			divisor_q <= divisor;
			rem_q     <= '0;
			quo_q     <= dividend;
		end else if (busy_q) begin
			rem_q <= borrow ? trial[STRIDE_W-1:0] : diff[STRIDE_W-1:0];
			quo_q <= {quo_q[POS_W-2:0], !borrow};
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/core/nd_pixel_address_generator.sv
// ----------------------------------------------------------------------------
// nd_pixel_address_generator
// Advance carries one dimension at a time; add-count adds the step to position and coordinate 0.
// Restart divides the start position level by level, from the top dimension down, in the shared divider.
// Carry normalizes dimension by dimension with a 13-bit divide on the same divider.
// After a size or dimension-count write the next item first rebuilds the
// strides, one multiply per dimension. Reset zeroes position and coordinates.
// ----------------------------------------------------------------------------
`include "nd_pixel_address_generator_assert.svh"

module nd_pixel_address_generator #(
	parameter int MAX_DIMS = ndpag_pkg::MAX_DIMS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ndpag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ndpag_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       operation,
	input  logic [ndpag_pkg::STEP_W-1:0]     step_count,
	input  logic [ndpag_pkg::MASK_W-1:0]     edge_mask,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ndpag_pkg::POS_W-1:0]      linear_offset,
	output logic [ndpag_pkg::COORD_W-1:0]    coord_0,
	output logic [ndpag_pkg::OCOORD_W-1:0]   coord_1,
	output logic [ndpag_pkg::OCOORD_W-1:0]   coord_2,
	output logic [ndpag_pkg::OCOORD_W-1:0]   coord_3,
	output logic                             at_end,
	output logic                             edge_any,
	output logic                             edge_right,
	output logic                             edge_any_masked,
	output logic                             edge_right_masked,
	output logic                             edge_first_dim
);
	import ndpag_pkg::*;

	localparam int DEPTH  = MAX_DIMS + 1;
	localparam int IW     = $clog2(MAX_DIMS + 1);
	localparam int PROD_W = STRIDE_W + SIZE_W;
	localparam int NOUT   = 4;

	typedef enum logic [1:0] {
		OP_RESTART = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_ADD     = 2'd2,
		OP_CARRY   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_DIM0     = 3'd0,
		REG_DIM1     = 3'd1,
		REG_DIM2     = 3'd2,
		REG_DIM3     = 3'd3,
		REG_NUM_DIMS = 3'd4,
		REG_START    = 3'd5,
		REG_END      = 3'd6,
		REG_FULL     = 3'd7
	} reg_idx_t;

	typedef enum logic [9:0] {
		S_IDLE      = 10'b0000000001,
		S_BUILD     = 10'b0000000010,
		S_ADV       = 10'b0000000100,
		S_ADDK      = 10'b0000001000,
		S_RST_INIT  = 10'b0000010000,
		S_RST_DIV   = 10'b0000100000,
		S_RST_WAIT  = 10'b0001000000,
		S_CAR_CHECK = 10'b0010000000,
		S_CAR_WAIT  = 10'b0100000000,
		S_DONE      = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic [POS_W-1:0]    linear_offset;
		logic [COORD_W-1:0]  coord_0;
		logic [OCOORD_W-1:0] coord_1;
		logic [OCOORD_W-1:0] coord_2;
		logic [OCOORD_W-1:0] coord_3;
		logic                at_end;
		logic                edge_any;
		logic                edge_right;
		logic                edge_any_masked;
		logic                edge_right_masked;
		logic                edge_first_dim;
	} result_t;

	function automatic state_t op_state(input op_t op);
		state_t s;
		unique case (op)
			OP_RESTART: s = S_RST_INIT;
			OP_ADVANCE: s = S_ADV;
			OP_ADD:     s = S_ADDK;
			OP_CARRY:   s = S_CAR_CHECK;
			default:    s = S_CAR_CHECK;
		endcase
		return s;
	endfunction

	logic [SIZE_W-1:0]     dim_size_q [CFG_DIM_REGS];
	logic [NUM_DIMS_W-1:0] num_dims_q;
	logic [POS_W-1:0]      range_start_q;
	logic [STRIDE_W-1:0]   range_end_q;
	logic                  range_full_q;

	state_t                state_q;
	logic                  dirty_q;
	logic [IW-1:0]         d_q;
	op_t                   op_q;
	logic [STEP_W-1:0]     step_q;
	logic [MASK_W-1:0]     mask_q;
	logic [STRIDE_W-1:0]   prod_q;
	logic [COORD_W-1:0]    qadd_q;
	logic [POS_W-1:0]      rem_q;
	logic [STRIDE_W-1:0]   total_q;
	logic [POS_W-1:0]      position_q;
	logic [COORD_W-1:0]    coord_q [DEPTH];
	logic [STRIDE_W-1:0]   stride_q [DEPTH];
	logic                  out_valid_q;
	result_t               res_q;

	logic                  cfg_we;
	logic                  dims_touch;
	logic                  accept;
	logic                  out_free;
	logic                  load_out;
	state_t                launch_state;
	logic [IW-1:0]         n_dims;
	logic [SIZE_W-1:0]     real_size [DEPTH];
	logic [SIZE_W-1:0]     size_vec [DEPTH];
	logic [SIZE_W-1:0]     size_cur;
	logic [PROD_W-1:0]     prod_full;
	logic [STRIDE_W-1:0]   prod_sat;
	logic [COORD_W-1:0]    adv_inc;
	logic                  adv_ge;
	logic [COORD_W-1:0]    car_cur;
	logic                  car_go;
	logic [STRIDE_W-1:0]   end_val;
	logic [MAX_DIMS-1:0]   used_v;
	logic [MAX_DIMS-1:0]   lo_v;
	logic [MAX_DIMS-1:0]   hi_v;
	logic [MAX_DIMS-1:0]   sel_v;
	logic [COORD_W-1:0]    coord_sel [NOUT];
	result_t               res_d;

	div_ctl_t              div_ctl;
	div_sts_t              div_sts;
	logic [POS_W-1:0]      div_dividend;
	logic [STRIDE_W-1:0]   div_divisor;
	logic [POS_W-1:0]      div_quo;
	logic [STRIDE_W-1:0]   div_rem;

	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign dims_touch = cfg_we && (reg_idx_t'(cfg_index) <= REG_NUM_DIMS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CFG_DIM_REGS; k++) begin
				dim_size_q[k] <= SIZE_W'(1);
			end
			num_dims_q    <= '0;
			range_start_q <= '0;
			range_end_q   <= '0;
			range_full_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DIM0:     dim_size_q[0] <= cfg_data[SIZE_W-1:0];
				REG_DIM1:     dim_size_q[1] <= cfg_data[SIZE_W-1:0];
				REG_DIM2:     dim_size_q[2] <= cfg_data[SIZE_W-1:0];
				REG_DIM3:     dim_size_q[3] <= cfg_data[SIZE_W-1:0];
				REG_NUM_DIMS: num_dims_q    <= cfg_data[NUM_DIMS_W-1:0];
				REG_START:    range_start_q <= cfg_data[POS_W-1:0];
				REG_END:      range_end_q   <= cfg_data[STRIDE_W-1:0];
				REG_FULL:     range_full_q  <= cfg_data[0];
				default:      range_full_q  <= range_full_q;
			endcase
		end
	end

	assign n_dims = (32'(num_dims_q) > MAX_DIMS) ? IW'(MAX_DIMS) : IW'(num_dims_q);

	for (genvar k = 0; k < DEPTH; k++) begin : g_size
		if (k < CFG_DIM_REGS) begin : g_reg
			assign real_size[k] = clamp_size(dim_size_q[k]);
		end else begin : g_one
			assign real_size[k] = SIZE_W'(1);
		end
		assign size_vec[k] = (IW'(k) == n_dims) ? SIZE_W'(SENTINEL_SIZE) : real_size[k];
	end

	assign size_cur  = size_vec[d_q];
	assign prod_full = PROD_W'(prod_q) * PROD_W'(size_cur);
	assign prod_sat  = (|prod_full[PROD_W-1:STRIDE_W]) ? '1 : prod_full[STRIDE_W-1:0];
	assign adv_inc   = coord_q[d_q] + COORD_W'(1);
	assign adv_ge    = adv_inc >= size_cur;
	assign car_cur   = coord_q[d_q] + qadd_q;
	assign car_go    = (d_q < n_dims) && (car_cur >= size_cur);

	assign out_free     = !out_valid_q || !out_stall;
	assign in_stall     = !((state_q == S_IDLE) || ((state_q == S_DONE) && out_free));
	assign accept       = in_valid && !in_stall;
	assign load_out     = (state_q == S_DONE) && out_free;
	assign launch_state = (dirty_q || dims_touch) ? S_BUILD : op_state(op_t'(operation));

	assign div_ctl.start = (state_q == S_RST_DIV) || ((state_q == S_CAR_CHECK) && car_go);
	assign div_ctl.count = (state_q == S_RST_DIV) ? DIV_CNT_W'(POS_W) : DIV_CNT_W'(COORD_W);
	assign div_dividend  = (state_q == S_RST_DIV) ? rem_q
		: {car_cur, {(POS_W - COORD_W){1'b0}}};
	assign div_divisor   = (state_q == S_RST_DIV) ? stride_q[d_q] : STRIDE_W'(size_cur);

	ndpag_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.sts       (div_sts),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			dirty_q    <= 1'b1;
			d_q        <= '0;
			op_q       <= OP_RESTART;
			step_q     <= '0;
			mask_q     <= '0;
			prod_q     <= STRIDE_W'(1);
			qadd_q     <= '0;
			rem_q      <= '0;
			total_q    <= '0;
			position_q <= '0;
			for (int k = 0; k < DEPTH; k++) begin
				coord_q[k] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					state_q <= S_IDLE;
				end
				S_BUILD: begin
					if (d_q == n_dims) begin
						total_q <= prod_q;
						dirty_q <= 1'b0;
						d_q     <= '0;
						state_q <= op_state(op_q);
					end else begin
						prod_q <= prod_sat;
						d_q    <= d_q + 1'b1;
					end
				end
				S_ADV: begin
					if (d_q == '0) begin
						position_q <= position_q + POS_W'(1);
					end
					coord_q[d_q] <= adv_ge ? (adv_inc - size_cur) : adv_inc;
					if (adv_ge && (d_q != n_dims)) begin
						d_q <= d_q + 1'b1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_ADDK: begin
					position_q <= position_q + POS_W'(step_q);
					coord_q[0] <= coord_q[0] + COORD_W'(step_q);
					state_q    <= S_DONE;
				end
				S_RST_INIT: begin
					position_q <= range_start_q;
					rem_q      <= range_start_q;
					d_q        <= n_dims;
					for (int k = 0; k < DEPTH; k++) begin
						if (IW'(k) > n_dims) begin
							coord_q[k] <= '0;
						end
					end
					state_q <= S_RST_DIV;
				end
				S_RST_DIV: begin
					state_q <= S_RST_WAIT;
				end
				S_RST_WAIT: begin
					if (div_sts.done) begin
						coord_q[d_q] <= div_quo[COORD_W-1:0];
						rem_q        <= div_rem[POS_W-1:0];
						if (d_q == '0) begin
							state_q <= S_DONE;
						end else begin
							d_q     <= d_q - 1'b1;
							state_q <= S_RST_DIV;
						end
					end
				end
				S_CAR_CHECK: begin
					coord_q[d_q] <= car_cur;
					state_q      <= car_go ? S_CAR_WAIT : S_DONE;
				end
				S_CAR_WAIT: begin
					if (div_sts.done) begin
						coord_q[d_q] <= div_rem[COORD_W-1:0];
						qadd_q       <= div_quo[COORD_W-1:0];
						d_q          <= d_q + 1'b1;
						state_q      <= S_CAR_CHECK;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (accept) begin
				op_q    <= op_t'(operation);
				step_q  <= step_count;
				mask_q  <= edge_mask;
				d_q     <= '0;
				prod_q  <= STRIDE_W'(1);
				qadd_q  <= '0;
				state_q <= launch_state;
			end
			if (dims_touch) begin
				dirty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_BUILD) begin
			stride_q[d_q] <= prod_q;
		end
	end

	for (genvar k = 0; k < MAX_DIMS; k++) begin : g_edge
		assign used_v[k] = IW'(k) < n_dims;
		assign lo_v[k]   = coord_q[k] == '0;
		assign hi_v[k]   = coord_q[k] == (real_size[k] - SIZE_W'(1));
		if (k < MASK_W) begin : g_sel
			assign sel_v[k] = mask_q[k];
		end else begin : g_nosel
			assign sel_v[k] = 1'b0;
		end
	end

	for (genvar k = 0; k < NOUT; k++) begin : g_out
		if (k <= MAX_DIMS) begin : g_live
			assign coord_sel[k] = (IW'(k) < n_dims) ? coord_q[k] : '0;
		end else begin : g_dead
			assign coord_sel[k] = '0;
		end
	end

	assign end_val = range_full_q ? total_q : range_end_q;

	always_comb begin
		res_d.linear_offset     = position_q;
		res_d.coord_0           = coord_sel[0];
		res_d.coord_1           = coord_sel[1][OCOORD_W-1:0];
		res_d.coord_2           = coord_sel[2][OCOORD_W-1:0];
		res_d.coord_3           = coord_sel[3][OCOORD_W-1:0];
		res_d.at_end            = STRIDE_W'(position_q) >= end_val;
		res_d.edge_any          = |(used_v & (lo_v | hi_v));
		res_d.edge_right        = |(used_v & hi_v);
		res_d.edge_any_masked   = |(used_v & sel_v & (lo_v | hi_v));
		res_d.edge_right_masked = |(used_v & sel_v & hi_v);
		res_d.edge_first_dim    = (n_dims != '0) && (lo_v[0] || hi_v[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q <= res_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign linear_offset     = res_q.linear_offset;
	assign coord_0           = res_q.coord_0;
	assign coord_1           = res_q.coord_1;
	assign coord_2           = res_q.coord_2;
	assign coord_3           = res_q.coord_3;
	assign at_end            = res_q.at_end;
	assign edge_any          = res_q.edge_any;
	assign edge_right        = res_q.edge_right;
	assign edge_any_masked   = res_q.edge_any_masked;
	assign edge_right_masked = res_q.edge_right_masked;
	assign edge_first_dim    = res_q.edge_first_dim;

	`NDPAG_ASSERT(a_div_start_idle, div_ctl.start |-> !div_sts.busy)
	`NDPAG_ASSERT(a_div_done_waited, div_sts.done |-> (state_q == S_RST_WAIT || state_q == S_CAR_WAIT))
	`NDPAG_ASSERT(a_word_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE))

endmodule

### verif/nd_pixel_address_generator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nd_pixel_address_generator_test
// Drives restart, step, skip and carry operations into the address generator
// under a series of array shapes and ranges, predicts every result word from
// a shadow copy of the walk state, and checks each word field by field while
// the input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module nd_pixel_address_generator_test;

	import ndpag_pkg::*;

	localparam longint unsigned STRIDE_MAX = (64'd1 << STRIDE_W) - 1;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned RANDOM_OPS = 1150;

	typedef enum logic [1:0] {
		OP_RESTART,
		OP_STEP,
		OP_SKIP,
		OP_CARRY
	} walk_op_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIM_SIZE_0,
		REG_DIM_SIZE_1,
		REG_DIM_SIZE_2,
		REG_DIM_SIZE_3,
		REG_NUM_DIMS,
		REG_RANGE_START,
		REG_RANGE_END,
		REG_RANGE_TO_FULL
	} reg_index_e;

	typedef struct packed {
		walk_op_e            op;
		logic [STEP_W-1:0]   cnt;
		logic [MASK_W-1:0]   msk;
		bit                  drain_first;
	} walk_cmd_t;

	typedef struct packed {
		logic [POS_W-1:0]    linear_offset;
		logic [COORD_W-1:0]  coord_0;
		logic [OCOORD_W-1:0] coord_1;
		logic [OCOORD_W-1:0] coord_2;
		logic [OCOORD_W-1:0] coord_3;
		logic                at_end;
		logic                edge_any;
		logic                edge_right;
		logic                edge_any_masked;
		logic                edge_right_masked;
		logic                edge_first_dim;
	} pixel_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            operation = '0;
	logic [STEP_W-1:0]     step_count = '0;
	logic [MASK_W-1:0]     edge_mask = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [POS_W-1:0]      linear_offset;
	logic [COORD_W-1:0]    coord_0;
	logic [OCOORD_W-1:0]   coord_1;
	logic [OCOORD_W-1:0]   coord_2;
	logic [OCOORD_W-1:0]   coord_3;
	logic                  at_end;
	logic                  edge_any;
	logic                  edge_right;
	logic                  edge_any_masked;
	logic                  edge_right_masked;
	logic                  edge_first_dim;

	logic [SIZE_W-1:0]     dim_size_reg [CFG_DIM_REGS] = '{1, 1, 1, 1};
	logic [NUM_DIMS_W-1:0] num_dims_reg = '0;
	logic [POS_W-1:0]      range_start_reg = '0;
	logic [STRIDE_W-1:0]   range_end_reg = '0;
	logic                  range_to_full_reg = 1'b1;

	logic [POS_W-1:0]      walk_pos = '0;
	logic [COORD_W-1:0]    walk_coord [MAX_DIMS_DEF+1] = '{default: '0};
	longint unsigned       walk_stride [MAX_DIMS_DEF+1] = '{default: 1};

	walk_cmd_t             pending_ops [$];
	pixel_report_t         expected_pixels [$];
	walk_cmd_t             next_cmd;
	pixel_report_t         seen_pixel;
	bit                    calm_phase = 1'b0;
	int unsigned           gap_left = 0;
	int unsigned           stall_left = 0;
	int unsigned           quiet_cycles = 0;
	int unsigned           err_count = 0;
	int unsigned           word_count = 0;

	nd_pixel_address_generator u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm_phase || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic flag_error(input string msg);
		if (err_count < 40) $display("mismatch: %s", msg);
		err_count++;
	endtask

	task automatic field_check(input string name, input longint unsigned got,
			input longint unsigned want);
		if (got != want)
			flag_error($sformatf("word %0d %s got %0h want %0h", word_count, name, got, want));
	endtask

	task automatic predict_walk(input logic [1:0] op_bits, input logic [STEP_W-1:0] cnt,
			input logic [MASK_W-1:0] msk);
		int                n;
		int                d;
		logic [SIZE_W-1:0] dim_len [MAX_DIMS_DEF+1];
		longint unsigned   rem;
		longint unsigned   q;
		longint unsigned   prod;
		longint unsigned   stop_mark;
		pixel_report_t     w;
		logic              lo;
		logic              hi;
		bit                carrying;
		n = (num_dims_reg > MAX_DIMS_DEF) ? MAX_DIMS_DEF : int'(num_dims_reg);
		for (d = 0; d <= MAX_DIMS_DEF; d++) dim_len[d] = 1;
		for (d = 0; d < n; d++) begin
			if (dim_size_reg[d] == 0) begin
				dim_len[d] = 1;
			end else if (dim_size_reg[d] > DIM_MAX) begin
				dim_len[d] = DIM_MAX;
			end else begin
				dim_len[d] = dim_size_reg[d];
			end
		end
		dim_len[n] = SENTINEL_SIZE;
		walk_stride[0] = 1;
		for (d = 1; d <= n; d++) begin
			prod = walk_stride[d-1] * dim_len[d-1];
			walk_stride[d] = (prod > STRIDE_MAX) ? STRIDE_MAX : prod;
		end
		case (walk_op_e'(op_bits))
			OP_RESTART: begin
				rem = range_start_reg;
				walk_pos = range_start_reg;
				for (d = n + 1; d <= MAX_DIMS_DEF; d++) walk_coord[d] = '0;
				for (d = n; d >= 0; d--) begin
					q = rem / walk_stride[d];
					rem = rem - q * walk_stride[d];
					walk_coord[d] = COORD_W'(q);
				end
			end
			OP_STEP: begin
				walk_pos = walk_pos + 1'b1;
				d = 0;
				carrying = 1'b1;
				while (carrying && d <= n) begin
					walk_coord[d] = walk_coord[d] + 1'b1;
					if (walk_coord[d] >= dim_len[d]) begin
						walk_coord[d] = walk_coord[d] - dim_len[d];
						d++;
					end else begin
						carrying = 1'b0;
					end
				end
			end
			OP_SKIP: begin
				walk_pos = walk_pos + POS_W'(cnt);
				walk_coord[0] = walk_coord[0] + COORD_W'(cnt);
			end
			OP_CARRY: begin
				d = 0;
				while (d < n && walk_coord[d] >= dim_len[d]) begin
					walk_coord[d+1] = walk_coord[d+1] + walk_coord[d] / dim_len[d];
					walk_coord[d] = walk_coord[d] % dim_len[d];
					d++;
				end
			end
		endcase
		stop_mark = range_to_full_reg ? walk_stride[n] : 64'(range_end_reg);
		w = '0;
		w.linear_offset = walk_pos;
		if (n > 0) w.coord_0 = walk_coord[0];
		if (n > 1) w.coord_1 = walk_coord[1][OCOORD_W-1:0];
		if (n > 2) w.coord_2 = walk_coord[2][OCOORD_W-1:0];
		if (n > 3) w.coord_3 = walk_coord[3][OCOORD_W-1:0];
		w.at_end = (64'(walk_pos) >= stop_mark);
		for (d = 0; d < n; d++) begin
			lo = (walk_coord[d] == 0);
			hi = (walk_coord[d] == dim_len[d] - 1'b1);
			if (lo || hi) w.edge_any = 1'b1;
			if (hi) w.edge_right = 1'b1;
			if (msk[d] && (lo || hi)) w.edge_any_masked = 1'b1;
			if (msk[d] && hi) w.edge_right_masked = 1'b1;
		end
		if (n > 0)
			w.edge_first_dim = (walk_coord[0] == 0) || (walk_coord[0] == dim_len[0] - 1'b1);
		expected_pixels.push_back(w);
	endtask

	task automatic check_pixel(input pixel_report_t got, input pixel_report_t want);
		field_check("linear_offset", got.linear_offset, want.linear_offset);
		field_check("coord_0", got.coord_0, want.coord_0);
		field_check("coord_1", got.coord_1, want.coord_1);
		field_check("coord_2", got.coord_2, want.coord_2);
		field_check("coord_3", got.coord_3, want.coord_3);
		field_check("at_end", got.at_end, want.at_end);
		field_check("edge_any", got.edge_any, want.edge_any);
		field_check("edge_right", got.edge_right, want.edge_right);
		field_check("edge_any_masked", got.edge_any_masked, want.edge_any_masked);
		field_check("edge_right_masked", got.edge_right_masked, want.edge_right_masked);
		field_check("edge_first_dim", got.edge_first_dim, want.edge_first_dim);
	endtask

	// driver: hold a stalled word, otherwise advance to the next pending op
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) predict_walk(operation, step_count, edge_mask);
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_ops.size() != 0 &&
						!(pending_ops[0].drain_first && expected_pixels.size() != 0)) begin
					next_cmd = pending_ops.pop_front();
					in_valid <= 1'b1;
					operation <= next_cmd.op;
					step_count <= next_cmd.cnt;
					edge_mask <= next_cmd.msk;
					gap_left <= pick_idle();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid === 1'b1 && !out_stall) begin
				seen_pixel = {linear_offset, coord_0, coord_1, coord_2, coord_3, at_end,
					edge_any, edge_right, edge_any_masked, edge_right_masked, edge_first_dim};
				if (expected_pixels.size() == 0) begin
					flag_error($sformatf("word %0d arrived with nothing expected", word_count));
				end else begin
					check_pixel(seen_pixel, expected_pixels.pop_front());
				end
				word_count++;
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= pick_idle();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) ||
					(cfg_valid && cfg_ready === 1'b1)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("nd_pixel_address_generator verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic cfg_write(input reg_index_e idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DIM_SIZE_0, REG_DIM_SIZE_1, REG_DIM_SIZE_2, REG_DIM_SIZE_3:
				dim_size_reg[idx] = data[SIZE_W-1:0];
			REG_NUM_DIMS:      num_dims_reg = data[NUM_DIMS_W-1:0];
			REG_RANGE_START:   range_start_reg = data[POS_W-1:0];
			REG_RANGE_END:     range_end_reg = data[STRIDE_W-1:0];
			REG_RANGE_TO_FULL: range_to_full_reg = data[0];
		endcase
	endtask

	task automatic apply_shape(input logic [SIZE_W-1:0] s0, input logic [SIZE_W-1:0] s1,
			input logic [SIZE_W-1:0] s2, input logic [SIZE_W-1:0] s3,
			input logic [NUM_DIMS_W-1:0] nd, input logic [POS_W-1:0] start_at,
			input logic [STRIDE_W-1:0] stop_at, input logic to_full);
		cfg_write(REG_DIM_SIZE_0, CFG_DATA_W'(s0));
		cfg_write(REG_DIM_SIZE_1, CFG_DATA_W'(s1));
		cfg_write(REG_DIM_SIZE_2, CFG_DATA_W'(s2));
		cfg_write(REG_DIM_SIZE_3, CFG_DATA_W'(s3));
		cfg_write(REG_NUM_DIMS, CFG_DATA_W'(nd));
		cfg_write(REG_RANGE_START, CFG_DATA_W'(start_at));
		cfg_write(REG_RANGE_END, CFG_DATA_W'(stop_at));
		cfg_write(REG_RANGE_TO_FULL, CFG_DATA_W'(to_full));
	endtask

	task automatic queue_op(input walk_op_e op, input int unsigned cnt, input int unsigned msk,
			input bit drain);
		walk_cmd_t c;
		c.op = op;
		c.cnt = STEP_W'(cnt);
		c.msk = MASK_W'(msk);
		c.drain_first = drain;
		pending_ops.push_back(c);
	endtask

	task automatic wait_drained();
		while (pending_ops.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int unsigned           made;
		int unsigned           phase_len;
		int unsigned           pick;
		int unsigned           k;
		int unsigned           n;
		logic [SIZE_W-1:0]     sz [CFG_DIM_REGS];
		logic [NUM_DIMS_W-1:0] nd;
		longint unsigned       span;
		logic [POS_W-1:0]      start_at;
		logic [STRIDE_W-1:0]   stop_at;
		walk_op_e              op;
		int unsigned           cnt;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		queue_op(OP_STEP, 0, 4'hF, 1'b0);
		queue_op(OP_SKIP, 4095, 4'h0, 1'b0);
		queue_op(OP_CARRY, 0, 4'h5, 1'b0);
		queue_op(OP_RESTART, 0, 4'hA, 1'b0);
		wait_drained();

		apply_shape(0, 8191, 4097, 3, 7, 48'hFFFF_FFFF_FFFF, 49'h1_0000_0000_0000, 1'b0);
		queue_op(OP_RESTART, 0, 4'hF, 1'b0);
		queue_op(OP_STEP, 0, 4'hF, 1'b0);
		queue_op(OP_SKIP, 4095, 4'h0, 1'b0);
		queue_op(OP_CARRY, 0, 4'h5, 1'b0);
		queue_op(OP_STEP, 0, 4'hA, 1'b0);
		queue_op(OP_RESTART, 4095, 4'h3, 1'b0);
		wait_drained();

		apply_shape(4096, 4096, 4096, 4096, 4, 0, 0, 1'b1);
		queue_op(OP_RESTART, 0, 4'hF, 1'b0);
		queue_op(OP_SKIP, 4095, 4'h1, 1'b0);
		queue_op(OP_SKIP, 4095, 4'h2, 1'b0);
		queue_op(OP_SKIP, 1, 4'h4, 1'b0);
		queue_op(OP_SKIP, 1, 4'h8, 1'b0);
		queue_op(OP_STEP, 0, 4'hF, 1'b0);
		queue_op(OP_CARRY, 0, 4'hF, 1'b0);
		wait_drained();

		apply_shape(2, 3, 1, 5, 3, 5, 7, 1'b0);
		queue_op(OP_RESTART, 0, 4'h7, 1'b0);
		queue_op(OP_STEP, 0, 4'h1, 1'b0);
		queue_op(OP_STEP, 0, 4'h2, 1'b0);
		queue_op(OP_SKIP, 10, 4'h4, 1'b0);
		queue_op(OP_STEP, 0, 4'h7, 1'b0);
		queue_op(OP_CARRY, 0, 4'h3, 1'b0);
		queue_op(OP_STEP, 0, 4'h6, 1'b0);
		wait_drained();

		made = 0;
		while (made < RANDOM_OPS) begin
			for (k = 0; k < CFG_DIM_REGS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) sz[k] = $urandom_range(1, 6);
				else if (pick < 80) sz[k] = $urandom_range(7, 64);
				else if (pick < 88) sz[k] = DIM_MAX;
				else if (pick < 93) sz[k] = 0;
				else if (pick < 97) sz[k] = $urandom_range(DIM_MAX + 1, 8191);
				else sz[k] = $urandom_range(1, DIM_MAX);
			end
			nd = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
			n = (nd > MAX_DIMS_DEF) ? MAX_DIMS_DEF : nd;
			span = 1;
			for (k = 0; k < n; k++)
				span = span * ((sz[k] == 0) ? 1 : (sz[k] > DIM_MAX) ? DIM_MAX : sz[k]);
			if ($urandom_range(0, 9) < 7) start_at = POS_W'({$urandom, $urandom} % span);
			else start_at = POS_W'({$urandom, $urandom});
			pick = $urandom_range(0, 99);
			if (pick < 50) stop_at = STRIDE_W'(start_at) + $urandom_range(0, 200);
			else if (pick < 80) stop_at = STRIDE_W'(span);
			else stop_at = STRIDE_W'({$urandom, $urandom});
			calm_phase <= ($urandom_range(0, 3) == 0);
			apply_shape(sz[0], sz[1], sz[2], sz[3], nd, start_at, stop_at, $urandom_range(0, 1));
			phase_len = $urandom_range(20, 80);
			queue_op(OP_RESTART, $urandom_range(0, 4095), $urandom_range(0, 15), 1'b0);
			for (k = 1; k < phase_len; k++) begin
				pick = $urandom_range(0, 99);
				cnt = $urandom_range(0, 4095);
				if (pick < 60) begin
					op = OP_STEP;
				end else if (pick < 72) begin
					op = OP_SKIP;
					if ($urandom_range(0, 3) != 0) cnt = $urandom_range(0, 15);
				end else if (pick < 85) begin
					op = OP_CARRY;
				end else if (pick < 95) begin
					op = OP_RESTART;
				end else begin
					op = walk_op_e'($urandom_range(0, 3));
				end
				queue_op(op, cnt, $urandom_range(0, 15), $urandom_range(0, 39) == 0);
			end
			made += phase_len;
			wait_drained();
		end

		repeat (12) @(posedge clk);
		if (err_count == 0) begin
			$display("nd_pixel_address_generator verification clean");
		end else begin
			$display("nd_pixel_address_generator verification failed");
		end
		$finish;
	end

endmodule
